// ===== sv/mcp_pkg.sv =====
// Shared types, codes and helpers of the MIDI channel message parser.
// No dependencies; used by mcp_parse and midi_channel_message_parser_unit.
package mcp_pkg;

  // Command nibbles (high nibble of a status byte)
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_POLY_AT  = 4'ha;
  localparam logic [3:0] CMD_CTRL     = 4'hb;
  localparam logic [3:0] CMD_PROGRAM  = 4'hc;
  localparam logic [3:0] CMD_CHAN_AT  = 4'hd;
  localparam logic [3:0] CMD_BEND     = 4'he;
  localparam logic [3:0] CMD_SYSTEM   = 4'hf;

  localparam logic [13:0] BEND_CENTER = 14'd8192;

  localparam int unsigned TDATA_W = 64;
  localparam int unsigned TUSER_W = 3;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_NOTE_ON  = 3'd2,
    KIND_CTRL     = 3'd3,
    KIND_BEND     = 3'd4,
    KIND_UNSUP    = 3'd5
  } event_kind_e;

  typedef struct packed {
    logic [7:0]      running_status;
    logic [1:0]      received_count;
    logic [1:0]      expected_count;
    logic [1:0][7:0] data_buf;
    logic            in_progress;
    logic            unsupported;
  } state_t;

  typedef struct packed {
    event_kind_e        event_kind;
    logic [3:0]         channel_number;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic signed [13:0] bend_amount;
    logic [1:0]         raw_length;
    logic [7:0]         raw_status;
    logic [7:0]         raw_first;
    logic [7:0]         raw_second;
    logic               accepted;
    logic               pending;
  } result_t;

  // Number of data bytes that follow a status byte; zero for system bytes.
  function automatic logic [1:0] data_len(input logic [7:0] status);
    logic [1:0] len;
    case (status[7:4]) inside
      CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_AT, CMD_CTRL, CMD_BEND: len = 2'd2;
      CMD_PROGRAM, CMD_CHAN_AT:                                   len = 2'd1;
      default:                                                    len = 2'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_supported(input logic [7:0] status);
    logic sup;
    case (status[7:4]) inside
      CMD_NOTE_OFF, CMD_NOTE_ON, CMD_CTRL, CMD_BEND: sup = 1'b1;
      default:                                       sup = 1'b0;
    endcase
    return sup;
  endfunction

endpackage

// ===== sv/mcp_parse.sv =====
// Next-state and result logic for one MIDI byte under running status.
// Purely combinational; depends on mcp_pkg.
module mcp_parse (
  input  mcp_pkg::state_t  state_i,
  input  logic [7:0]       byte_i,
  output mcp_pkg::state_t  state_o,
  output mcp_pkg::result_t res_o
);
  import mcp_pkg::*;

  always_comb begin
    state_t      st;
    result_t     res;
    logic        acc;
    logic [1:0]  len;
    logic [1:0]  rc_inc;
    logic [13:0] bend_sum;

    st       = state_i;
    res      = '0;
    acc      = 1'b0;
    len      = data_len(byte_i);
    rc_inc   = state_i.received_count + 2'd1;
    bend_sum = '0;

    if (byte_i[7]) begin
      if (len == 2'd0) begin
        // system byte: report alone and drop running status
        res.event_kind    = KIND_UNSUP;
        res.raw_length    = 2'd1;
        res.raw_status    = byte_i;
        st.running_status = '0;
        st.received_count = '0;
        st.expected_count = '0;
        st.in_progress    = 1'b0;
      end else begin
        st.running_status = byte_i;
        st.received_count = '0;
        st.expected_count = len;
        st.in_progress    = 1'b1;
        st.unsupported    = ~is_supported(byte_i);
        acc               = 1'b1;
      end
    end else if (state_i.running_status != '0 && state_i.expected_count != '0) begin
      st.data_buf[state_i.received_count[0]] = byte_i;
      st.received_count = rc_inc;
      acc               = 1'b1;
      if (rc_inc >= state_i.expected_count) begin
        st.received_count = '0;
        if (state_i.unsupported) begin
          res.event_kind = KIND_UNSUP;
          res.raw_length = state_i.expected_count + 2'd1;
          res.raw_status = state_i.running_status;
          res.raw_first  = st.data_buf[0];
          res.raw_second = (state_i.expected_count > 2'd1) ? st.data_buf[1] : 8'd0;
          st.in_progress = 1'b0;
        end else begin
          bend_sum = {st.data_buf[1][6:0], 7'd0} + {6'd0, st.data_buf[0]} - BEND_CENTER;
          case (state_i.running_status[7:4])
            CMD_NOTE_OFF: res.event_kind = KIND_NOTE_OFF;
            CMD_NOTE_ON:  res.event_kind = KIND_NOTE_ON;
            CMD_CTRL:     res.event_kind = KIND_CTRL;
            CMD_BEND:     res.event_kind = KIND_BEND;
            default:      res.event_kind = KIND_NONE;
          endcase
          if (res.event_kind == KIND_NONE) begin
            acc = 1'b0;
          end else begin
            res.channel_number = state_i.running_status[3:0];
            if (res.event_kind == KIND_BEND) begin
              res.bend_amount = signed'(bend_sum);
            end else begin
              res.first_data  = st.data_buf[0];
              res.second_data = st.data_buf[1];
            end
            st.in_progress = 1'b0;
            st.unsupported = 1'b0;
          end
        end
      end
    end

    res.accepted = acc;
    res.pending  = st.in_progress;
    state_o      = st;
    res_o        = res;
  end

endmodule

// ===== sv/midi_channel_message_parser_unit.sv =====
// Top level of the MIDI channel message parser: stream ports, input and result registers.
// Depends on mcp_pkg and mcp_parse.
//
// Takes one MIDI byte per item and returns exactly one result item per byte. A new byte is
// accepted every clock cycle unless the result side stalls; a byte passes through the input
// register, then the parse logic into the result register. Backpressure on
// the result side stalls the input register and the parser state together, so throughput is
// one byte per cycle whenever the result side is ready. Status bytes F0..FF are reported as
// one-byte unsupported messages and end running status; A, C and D messages come out raw.
module midi_channel_message_parser_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] midi_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] channel_number, [11:4] first_data, [19:12] second_data, [33:20] bend_amount,
  // [35:34] raw_length, [43:36] raw_status, [51:44] raw_first, [59:52] raw_second,
  // [60] accepted, [61] pending, [63:62] zero
  output logic [mcp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [mcp_pkg::TUSER_W-1:0] m_axis_tuser   // [2:0] event_kind
);
  import mcp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_res_q;
  state_t     state_q;
  state_t     state_d;
  result_t    res_d;
  logic       advance;

  // result register free or draining this cycle
  assign advance       = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~in_valid_q | advance;

  mcp_parse u_parse (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && in_valid_q) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.event_kind;
  assign m_axis_tdata  = {2'b00,
                          out_res_q.pending,
                          out_res_q.accepted,
                          out_res_q.raw_second,
                          out_res_q.raw_first,
                          out_res_q.raw_status,
                          out_res_q.raw_length,
                          out_res_q.bend_amount,
                          out_res_q.second_data,
                          out_res_q.first_data,
                          out_res_q.channel_number};

  // no running status means nothing is expected
  a_no_status_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.running_status == '0 |-> state_q.expected_count == '0)
    else $error("expected count set without running status");

  // between bytes the received count is zero or below the expected count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.received_count < state_q.expected_count) || (state_q.received_count == '0))
    else $error("received count out of range");

  a_progress_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_progress |-> state_q.running_status[7])
    else $error("message in progress without a status byte");

  a_unsup_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.event_kind == KIND_UNSUP) |-> out_res_q.raw_length != '0)
    else $error("unsupported result with zero length");

endmodule

// ===== tb/sv/midi_channel_message_parser_unit_tb.sv =====
// Testbench for midi_channel_message_parser_unit: streams MIDI bytes in, predicts each result
// with its own running-status parser and checks every result item field by field.
// Depends on mcp_pkg and the parser RTL.
`timescale 1ns / 1ps

module midi_channel_message_parser_unit_tb;
  import mcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_PATTERN,
    RX_LIGHT
  } rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [TUSER_W-1:0]  m_axis_tuser;

  midi_channel_message_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Parser state as the predictor sees it
  logic [7:0]      run_status;
  logic [1:0]      rx_count;
  logic [1:0]      want_count;
  logic [7:0]      data_bytes [2];
  logic            msg_busy;
  logic            raw_mode;

  result_t         expected_results [$];
  int unsigned     bytes_sent = 0;
  int unsigned     bytes_ignored = 0;
  int unsigned     results_seen = 0;
  int unsigned     mismatches = 0;
  int unsigned     kind_seen [6];
  int unsigned     cycle_count = 0;

  int unsigned     burst_left = 0;
  bit              steady_send = 1'b0;
  rx_mode_e        rx_mode = RX_ALWAYS;
  int unsigned     hold_request = 0;
  int unsigned     hold_left = 0;
  logic [7:0]      stall_pattern = 8'hff;
  int unsigned     pattern_age = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("midi_channel_message_parser_unit_tb failed");
      $finish;
    end
  end

  // Result side: a long hold-off when asked, else always ready or a rotating stall pattern by mode
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      pattern_age++;
      if (pattern_age % 32 == 0) stall_pattern = 8'($urandom);
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_PATTERN: m_axis_tready <= stall_pattern[0];
        default:    m_axis_tready <= (stall_pattern[2:0] != 3'b000);
      endcase
    end
  end

  task automatic clear_parser_state();
    run_status = 8'h00;
    rx_count = 2'd0;
    want_count = 2'd0;
    data_bytes[0] = 8'h00;
    data_bytes[1] = 8'h00;
    msg_busy = 1'b0;
    raw_mode = 1'b0;
  endtask

  // Advance the parser state by one byte and return the result it produces
  function automatic result_t parse_midi_byte(input logic [7:0] midi_byte);
    result_t    r;
    logic [3:0] cmd;
    logic [1:0] need;
    logic       took;
    int         bend;
    r = '0;
    took = 1'b0;
    cmd = midi_byte[7:4];
    if (midi_byte[7]) begin
      case (cmd)
        CMD_PROGRAM, CMD_CHAN_AT: need = 2'd1;
        CMD_SYSTEM:               need = 2'd0;
        default:                  need = 2'd2;
      endcase
      if (need == 2'd0) begin
        // system byte: report alone and drop running status
        r.event_kind = KIND_UNSUP;
        r.raw_length = 2'd1;
        r.raw_status = midi_byte;
        run_status = 8'h00;
        rx_count = 2'd0;
        want_count = 2'd0;
        msg_busy = 1'b0;
      end else begin
        run_status = midi_byte;
        rx_count = 2'd0;
        want_count = need;
        msg_busy = 1'b1;
        raw_mode = !(cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON || cmd == CMD_CTRL ||
                     cmd == CMD_BEND);
        took = 1'b1;
      end
    end else if (run_status != 8'h00 && want_count != 2'd0) begin
      data_bytes[rx_count[0]] = midi_byte;
      rx_count = rx_count + 2'd1;
      took = 1'b1;
      if (rx_count >= want_count) begin
        cmd = run_status[7:4];
        rx_count = 2'd0;
        if (raw_mode) begin
          r.event_kind = KIND_UNSUP;
          r.raw_length = want_count + 2'd1;
          r.raw_status = run_status;
          r.raw_first = data_bytes[0];
          r.raw_second = (want_count > 2'd1) ? data_bytes[1] : 8'h00;
          msg_busy = 1'b0;
        end else begin
          r.channel_number = run_status[3:0];
          r.first_data = data_bytes[0];
          r.second_data = data_bytes[1];
          case (cmd)
            CMD_NOTE_OFF: r.event_kind = KIND_NOTE_OFF;
            CMD_NOTE_ON:  r.event_kind = KIND_NOTE_ON;
            CMD_CTRL:     r.event_kind = KIND_CTRL;
            CMD_BEND: begin
              bend = int'(data_bytes[1]) * 128 + int'(data_bytes[0]) - int'(BEND_CENTER);
              r.event_kind = KIND_BEND;
              r.first_data = 8'h00;
              r.second_data = 8'h00;
              r.bend_amount = bend[13:0];
            end
            default: r.event_kind = KIND_NONE;
          endcase
          if (r.event_kind == KIND_NONE) begin
            r = '0;
            took = 1'b0;
          end else begin
            msg_busy = 1'b0;
            raw_mode = 1'b0;
          end
        end
      end
    end else begin
      bytes_ignored++;
    end
    r.accepted = took;
    r.pending = msg_busy;
    return r;
  endfunction

  // Offer one byte in bursts with random gaps; record its result once accepted
  task automatic send_byte(input logic [7:0] midi_byte);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= midi_byte;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(parse_midi_byte(midi_byte));
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Stop offering and hold until every outstanding result has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void note_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s of result %0d: expected %h, got %h", name, results_seen,
                 want, got);
    end
  endfunction

  task automatic check_result();
    result_t got;
    result_t want;
    got.event_kind     = event_kind_e'(m_axis_tuser[2:0]);
    got.channel_number = m_axis_tdata[3:0];
    got.first_data     = m_axis_tdata[11:4];
    got.second_data    = m_axis_tdata[19:12];
    got.bend_amount    = m_axis_tdata[33:20];
    got.raw_length     = m_axis_tdata[35:34];
    got.raw_status     = m_axis_tdata[43:36];
    got.raw_first      = m_axis_tdata[51:44];
    got.raw_second     = m_axis_tdata[59:52];
    got.accepted       = m_axis_tdata[60];
    got.pending        = m_axis_tdata[61];
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d arrived with nothing outstanding: %p", results_seen, got);
    end else begin
      want = expected_results.pop_front();
      note_field("event_kind", 64'(want.event_kind), 64'(got.event_kind));
      note_field("channel_number", 64'(want.channel_number), 64'(got.channel_number));
      note_field("first_data", 64'(want.first_data), 64'(got.first_data));
      note_field("second_data", 64'(want.second_data), 64'(got.second_data));
      note_field("bend_amount", 64'(want.bend_amount), 64'(got.bend_amount));
      note_field("raw_length", 64'(want.raw_length), 64'(got.raw_length));
      note_field("raw_status", 64'(want.raw_status), 64'(got.raw_status));
      note_field("raw_first", 64'(want.raw_first), 64'(got.raw_first));
      note_field("raw_second", 64'(want.raw_second), 64'(got.raw_second));
      note_field("accepted", 64'(want.accepted), 64'(got.accepted));
      note_field("pending", 64'(want.pending), 64'(got.pending));
      note_field("tdata padding", 64'd0, 64'(m_axis_tdata[63:62]));
      kind_seen[int'(want.event_kind)]++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
  end

  // Data with no status yet must be ignored
  task automatic test_orphan_data();
    send_byte(8'h7f);
  endtask

  task automatic test_channel_messages();
    send_bytes('{8'h80, 8'h00, 8'h7f});        // note off, lowest channel
    send_bytes('{8'h9f, 8'h7f, 8'h01});        // note on, highest channel
    send_bytes('{8'hba, 8'h07, 8'h64});
    send_bytes('{8'he3, 8'h00, 8'h00});        // bend, most negative
    send_bytes('{8'h7f, 8'h7f});               // running status, most positive bend
  endtask

  task automatic test_raw_messages();
    send_bytes('{8'ha3, 8'h10, 8'h20});
    send_bytes('{8'hc2, 8'h05});
    send_bytes('{8'hd1, 8'h7f});
  endtask

  // System byte cuts a message short; the following data has no status
  task automatic test_system_bytes();
    send_bytes('{8'h90, 8'h40, 8'hf8, 8'h22, 8'hff});
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input rx_mode_e mode,
                                     input bit steady);
    int unsigned start;
    int unsigned pick;
    int unsigned need;
    int unsigned count;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [7:0]  status;
    logic [7:0]  value;
    rx_mode = mode;
    steady_send = steady;
    start = bytes_sent - bytes_ignored;
    status = 8'h00;
    while (bytes_sent - bytes_ignored - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        // well-formed message, sometimes reusing the running status
        if (status == 8'h00 || pick >= 60 || $urandom_range(2) == 0) begin
          hi = 4'($urandom_range(CMD_NOTE_OFF, CMD_BEND));
          lo = 4'($urandom_range(15));
          status = {hi, lo};
          send_byte(status);
        end
        need = (status[7:4] == CMD_PROGRAM || status[7:4] == CMD_CHAN_AT) ? 1 : 2;
        // truncate some messages to leave a partial one behind
        count = (pick >= 60) ? $urandom_range(0, need - 1) : need;
        repeat (count) begin
          value = 8'($urandom_range(127));
          send_byte(value);
        end
      end else if (pick < 85) begin
        lo = 4'($urandom_range(15));
        send_byte({CMD_SYSTEM, lo});
        status = 8'h00;
      end else begin
        value = 8'($urandom_range(255));
        send_byte(value);
        status = 8'h00;
      end
    end
  endtask

  // Hold the result side long enough for the block to stall its input
  task automatic test_output_stall();
    rx_mode = RX_ALWAYS;
    hold_request = 150;
    test_random_traffic(60, RX_ALWAYS, 1'b1);
  endtask

  initial begin
    clear_parser_state();
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_orphan_data();
    test_channel_messages();
    test_raw_messages();
    test_system_bytes();
    wait_for_drain();
    test_output_stall();
    wait_for_drain();
    test_random_traffic(150, RX_PATTERN, 1'b0);
    test_random_traffic(120, RX_ALWAYS, 1'b1);
    wait_for_drain();
    test_random_traffic(140, RX_LIGHT, 1'b0);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    mismatches += expected_results.size();
    $display("sent %0d bytes (%0d ignored), checked %0d results", bytes_sent, bytes_ignored,
             results_seen);
    $display("kinds: none %0d, note off %0d, note on %0d, control %0d, bend %0d, raw %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (mismatches == 0) begin
      $display("midi_channel_message_parser_unit_tb passed");
    end else begin
      $display("midi_channel_message_parser_unit_tb failed");
    end
    $finish;
  end

endmodule
